FILE: rtl/modular_exponentiation_unit_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the modular exponentiation unit
// Clocked on clk, disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef MODULAR_EXPONENTIATION_UNIT_ASSERT_SVH
`define MODULAR_EXPONENTIATION_UNIT_ASSERT_SVH

// same-cycle implication
`define MEXP_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MEXP_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/mexp_pkg.sv
// ---------------------------------------------------------------------------
// mexp_pkg
// Shared constants, control word layout and microcode ROM of the
// modular exponentiation unit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package mexp_pkg;

	localparam int DEF_WIDTH = 32;
	localparam int FIELD_W   = 32;
	localparam int STEP_W    = 3;

	// microcode step addresses
	localparam logic [STEP_W-1:0] STEP_IDLE = 3'd0;
	localparam logic [STEP_W-1:0] STEP_CHK  = 3'd1;
	localparam logic [STEP_W-1:0] STEP_RED  = 3'd2;
	localparam logic [STEP_W-1:0] STEP_SQR  = 3'd3;
	localparam logic [STEP_W-1:0] STEP_TST  = 3'd4;
	localparam logic [STEP_W-1:0] STEP_MUL  = 3'd5;
	localparam logic [STEP_W-1:0] STEP_NXT  = 3'd6;
	localparam logic [STEP_W-1:0] STEP_OUT  = 3'd7;

	// jump conditions
	typedef enum logic [2:0] {
		COND_NONE,       // fall through
		COND_ALWAYS,     // unconditional jump
		COND_NOT_START,  // jump unless a transaction is accepted
		COND_MOD_LE1,    // jump if modulus is 0 or 1
		COND_BIT_CLR,    // jump if current exponent bit is clear
		COND_CNT_NZ      // jump if bits remain (and advance the bit)
	} cond_t;

	// one control word per step
	typedef struct packed {
		logic              mul;      // run the modular multiplier
		logic              a_acc;    // multiplicand: 0 = one, 1 = accumulator
		logic              b_acc;    // multiplier: 0 = base, 1 = accumulator
		logic              dst_acc;  // product goes to: 0 = base, 1 = accumulator
		logic              init;     // load accumulator and bit counter
		logic              emit;     // present result
		cond_t             cond;
		logic [STEP_W-1:0] target;
	} cword_t;

	// microcode ROM
	function automatic cword_t rom_word(input logic [STEP_W-1:0] step);
		cword_t w;
		w = '{mul: 1'b0, a_acc: 1'b0, b_acc: 1'b0, dst_acc: 1'b0, init: 1'b0,
			emit: 1'b0, cond: COND_NONE, target: STEP_IDLE};
		unique case (step)
			STEP_IDLE: begin
				w.cond   = COND_NOT_START;
				w.target = STEP_IDLE;
			end
			STEP_CHK: begin
				w.init   = 1'b1;
				w.cond   = COND_MOD_LE1;
				w.target = STEP_OUT;
			end
			// base := 1 * base mod n
			STEP_RED: begin
				w.mul = 1'b1;
			end
			STEP_SQR: begin
				w.mul     = 1'b1;
				w.a_acc   = 1'b1;
				w.b_acc   = 1'b1;
				w.dst_acc = 1'b1;
			end
			STEP_TST: begin
				w.cond   = COND_BIT_CLR;
				w.target = STEP_NXT;
			end
			STEP_MUL: begin
				w.mul     = 1'b1;
				w.a_acc   = 1'b1;
				w.dst_acc = 1'b1;
			end
			STEP_NXT: begin
				w.cond   = COND_CNT_NZ;
				w.target = STEP_SQR;
			end
			STEP_OUT: begin
				w.emit   = 1'b1;
				w.cond   = COND_ALWAYS;
				w.target = STEP_IDLE;
			end
			default: ;
		endcase
		return w;
	endfunction

endpackage

FILE: rtl/mexp_mulmod.sv
// ---------------------------------------------------------------------------
// mexp_mulmod
// Iterative modular multiplier: prod = a * b mod m, one multiplier bit per
// cycle, MSB first, by double-and-add with a three-way reduction.
// Requires a < m; b may be any value.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mexp_mulmod
	import mexp_pkg::*;
#(
	parameter int WIDTH = DEF_WIDTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [WIDTH-1:0] a,
	input  logic [WIDTH-1:0] b,
	input  logic [WIDTH-1:0] m,
	output logic             done,
	output logic [WIDTH-1:0] prod
);

	localparam int CW = $clog2(WIDTH);

	logic             busy_q;
	logic             done_q;
	logic [CW-1:0]    cnt_q;
	logic [WIDTH-1:0] acc_q;
	logic [WIDTH-1:0] a_q;
	logic [WIDTH-1:0] b_q;
	logic [WIDTH-1:0] m_q;

	logic [WIDTH+1:0] sum_w;
	logic [WIDTH+1:0] m1_w;
	logic [WIDTH+1:0] m2_w;
	logic [WIDTH+1:0] red_w;

	// 2*acc + bit*a is below 3m: subtract 0, m or 2m
	always_comb begin
		m1_w  = {2'b00, m_q};
		m2_w  = {1'b0, m_q, 1'b0};
		sum_w = {1'b0, acc_q, 1'b0} + (b_q[WIDTH-1] ? {2'b00, a_q} : '0);
		priority if (sum_w >= m2_w) begin
			red_w = sum_w - m2_w;
		end else if (sum_w >= m1_w) begin
			red_w = sum_w - m1_w;
		end else begin
			red_w = sum_w;
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && (cnt_q == '0)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			a_q   <= a;
			b_q   <= b;
			m_q   <= m;
			cnt_q <= CW'(WIDTH - 1);
		end else if (busy_q) begin
			acc_q <= red_w[WIDTH-1:0];
			b_q   <= {b_q[WIDTH-2:0], 1'b0};
			cnt_q <= cnt_q - 1'b1;
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

FILE: rtl/modular_exponentiation_unit.sv
// ---------------------------------------------------------------------------
// modular_exponentiation_unit
// Computes base_value ^ exponent mod modulus by square-and-multiply.
// ---------------------------------------------------------------------------
// A transaction is taken when start is high while busy is low. The result
// appears on power_mod for exactly one cycle with done high; it must be
// captured then, since the receiver cannot stall the unit. busy stays high
// from the cycle after acceptance until the result cycle. The unit works
// on one transaction at a time. Run time is set by the bit-serial modular
// multiplier and grows with the number of set exponent bits. A modulus of
// 0 or 1 returns 0 without running the multiplier. Write the modulus
// (cfg_wr_en, cfg_wr_data) only while idle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module modular_exponentiation_unit
	import mexp_pkg::*;
#(
	parameter int WIDTH = DEF_WIDTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [FIELD_W-1:0] cfg_wr_data,
	input  logic               start,
	input  logic [FIELD_W-1:0] base_value,
	input  logic [FIELD_W-1:0] exponent,
	output logic               busy,
	output logic               done,
	output logic [FIELD_W-1:0] power_mod
);

	`include "modular_exponentiation_unit_assert.svh"

	localparam int CW = $clog2(WIDTH);

	logic [WIDTH-1:0]   modulus_q;
	logic [STEP_W-1:0]  step_q;
	logic [STEP_W-1:0]  step_nxt;
	logic [WIDTH-1:0]   base_q;
	logic [WIDTH-1:0]   exp_q;
	logic [WIDTH-1:0]   acc_q;
	logic [CW-1:0]      cnt_q;
	logic               mul_pend_q;
	logic               done_q;
	logic [FIELD_W-1:0] power_mod_q;

	cword_t             cw;
	logic               accept;
	logic               mod_le1;
	logic               taken;
	logic               mul_start;
	logic               mul_done;
	logic [WIDTH-1:0]   mul_a;
	logic [WIDTH-1:0]   mul_b;
	logic [WIDTH-1:0]   mul_prod;

	assign cw      = rom_word(step_q);
	assign accept  = start && (step_q == STEP_IDLE);
	assign mod_le1 = (modulus_q <= WIDTH'(1));

	// jump condition
	always_comb begin
		unique case (cw.cond)
			COND_NONE:      taken = 1'b0;
			COND_ALWAYS:    taken = 1'b1;
			COND_NOT_START: taken = !start;
			COND_MOD_LE1:   taken = mod_le1;
			COND_BIT_CLR:   taken = !exp_q[WIDTH-1];
			COND_CNT_NZ:    taken = (cnt_q != '0);
			default:        taken = 1'b0;
		endcase
	end

	// sequencer: multiply steps hold until the multiplier finishes
	always_comb begin
		priority if (cw.mul) begin
			step_nxt = mul_done ? step_q + 1'b1 : step_q;
		end else if (taken) begin
			step_nxt = cw.target;
		end else begin
			step_nxt = step_q + 1'b1;
		end
	end

	assign mul_start = cw.mul && !mul_pend_q;
	assign mul_a     = cw.a_acc ? acc_q : WIDTH'(1);
	assign mul_b     = cw.b_acc ? acc_q : base_q;

	// modulus register and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q  <= WIDTH'(1);
			step_q     <= STEP_IDLE;
			mul_pend_q <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				modulus_q <= WIDTH'(cfg_wr_data);
			end
			step_q <= step_nxt;
			if (mul_start) begin
				mul_pend_q <= 1'b1;
			end else if (mul_done) begin
				mul_pend_q <= 1'b0;
			end
			done_q <= cw.emit;
		end
	end

	// operand and accumulator registers
	always_ff @(posedge clk) begin
		if (accept) begin
			base_q <= WIDTH'(base_value);
			exp_q  <= WIDTH'(exponent);
		end
		if (cw.init) begin
			acc_q <= mod_le1 ? '0 : WIDTH'(1);
			cnt_q <= CW'(WIDTH - 1);
		end
		if (cw.mul && mul_done) begin
			if (cw.dst_acc) begin
				acc_q <= mul_prod;
			end else begin
				base_q <= mul_prod;
			end
		end
		if ((cw.cond == COND_CNT_NZ) && (cnt_q != '0)) begin
			cnt_q <= cnt_q - 1'b1;
			exp_q <= {exp_q[WIDTH-2:0], 1'b0};
		end
		if (cw.emit) begin
			power_mod_q <= FIELD_W'(acc_q);
		end
	end

	mexp_mulmod #(
		.WIDTH(WIDTH)
	) u_mulmod (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mul_start),
		.a     (mul_a),
		.b     (mul_b),
		.m     (modulus_q),
		.done  (mul_done),
		.prod  (mul_prod)
	);

	assign busy      = (step_q != STEP_IDLE);
	assign done      = done_q;
	assign power_mod = power_mod_q;

	// checks
	`MEXP_ASSERT_NXT(a_accept_chk, accept, step_q == STEP_CHK, "accept did not start program")
	`MEXP_ASSERT_IMP(a_mul_done_pend, mul_done, mul_pend_q && cw.mul, "stray multiplier done")
	`MEXP_ASSERT_IMP(a_done_idle, done_q, step_q == STEP_IDLE, "result strobe while running")

endmodule

FILE: dv/modular_exponentiation_unit_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// modular_exponentiation_unit_test
// Self-checking bench for the modular exponentiation unit. A directed table
// covers the reset modulus, moduli of zero and one, a zero exponent, the
// field extremes and a Fermat identity. Bursts of random transactions follow,
// each burst under a freshly written modulus. Each result is checked against a
// typed-in value or an exact square-and-multiply model held in the bench.
// ---------------------------------------------------------------------------

module modular_exponentiation_unit_test
	import mexp_pkg::*;
();

	localparam int RESET_CYCLES  = 7;
	localparam int RANDOM_ITEMS  = 268;
	localparam int STALL_LIMIT   = 20000;
	localparam int SETTLE_CYCLES = 8;
	localparam int DIR_N         = 22;
	localparam int IDLE_FIRST    = 28;
	localparam int IDLE_SECOND   = 46;
	localparam int MAX_GAP       = 24;

	typedef logic [FIELD_W-1:0] word_t;

	// one row of the directed table
	typedef struct packed {
		logic  wr_mod;    // write mod_val before this transaction
		word_t mod_val;
		word_t base_val;
		word_t exp_val;
		logic  known;     // want is typed in; otherwise use the model
		word_t want;
	} dir_row_t;

	logic  clk         = 1'b0;
	logic  arst_n      = 1'b0;
	logic  cfg_wr_en   = 1'b0;
	word_t cfg_wr_data = '0;
	logic  start       = 1'b0;
	word_t base_value  = '0;
	word_t exponent    = '0;
	logic  busy;
	logic  done;
	word_t power_mod;

	word_t    power_due[$];
	word_t    modulus_copy = word_t'(1);
	dir_row_t dir_rows[DIR_N];
	int       errors       = 0;
	int       items_sent   = 0;
	int       results_seen = 0;
	int       mod_writes   = 0;
	int       stall_cycles = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	modular_exponentiation_unit #(
		.WIDTH(DEF_WIDTH)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.start      (start),
		.base_value (base_value),
		.exponent   (exponent),
		.busy       (busy),
		.done       (done),
		.power_mod  (power_mod)
	);

	// exact b^e mod m, MSB-first square-and-multiply on 64-bit products
	function automatic word_t pow_mod(input word_t b, input word_t e, input word_t m);
		logic [63:0] acc;
		logic [63:0] red_base;
		logic [63:0] m64;
		if (m <= word_t'(1))
			return '0;
		m64      = {32'b0, m};
		red_base = {32'b0, b} % m64;
		acc      = 64'd1;
		for (int i = FIELD_W - 1; i >= 0; i--) begin
			acc = (acc * acc) % m64;
			if (e[i])
				acc = (acc * red_base) % m64;
		end
		return acc[FIELD_W-1:0];
	endfunction

	// present one transaction, optionally after an idle gap; returns after acceptance
	task automatic send_item(input word_t b, input word_t e, input logic known,
			input word_t want, input int idle_pct);
		int gap;
		gap = 0;
		if (idle_pct > 0 && $urandom_range(99) < idle_pct)
			gap = $urandom_range(MAX_GAP, 1);
		if (gap > 0) begin
			start <= 1'b0;
			// the gap counts only cycles in which the unit could accept
			do @(posedge clk); while (busy);
			repeat (gap - 1) @(posedge clk);
		end
		start      <= 1'b1;
		base_value <= b;
		exponent   <= e;
		do @(posedge clk); while (busy);
		power_due.push_back(known ? want : pow_mod(b, e, modulus_copy));
		items_sent++;
	endtask

	// drain outstanding results, let the unit settle, then write the modulus
	task automatic set_modulus(input word_t m);
		start <= 1'b0;
		while (power_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_wr_en    <= 1'b1;
		cfg_wr_data  <= m;
		modulus_copy = m;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		mod_writes++;
	endtask

	// result check and stall watchdog
	always @(posedge clk) begin
		word_t want;
		if (arst_n) begin
			if ((start && !busy) || done)
				stall_cycles = 0;
			else
				stall_cycles++;
			if (done) begin
				results_seen++;
				if (power_due.size() == 0) begin
					$display("%0t: unexpected result: expected none, actual %h",
						$time, power_mod);
					errors++;
				end else begin
					want = power_due.pop_front();
					if (power_mod !== want) begin
						$display("%0t: power_mod mismatch: expected %h, actual %h",
							$time, want, power_mod);
						errors++;
					end
				end
			end
			if (stall_cycles >= STALL_LIMIT) begin
				$display("%0t: no transaction for %0d cycles, %0d results outstanding",
					$time, stall_cycles, power_due.size());
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	// stimulus
	initial begin
		dir_row_t row;
		word_t    m;
		word_t    b;
		word_t    e;
		int       rand_sent;
		int       burst;
		int       idle_pct;

		dir_rows = '{
			// reset modulus of one
			'{1'b0, 32'h0,        32'd5,        32'd3,        1'b1, 32'h0},
			'{1'b0, 32'h0,        32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 32'h0},
			// modulus zero
			'{1'b1, 32'h0,        32'd7,        32'd5,        1'b1, 32'h0},
			'{1'b0, 32'h0,        32'h0,        32'h0,        1'b1, 32'h0},
			// modulus one written explicitly
			'{1'b1, 32'h1,        32'hFFFFFFFF, 32'h0,        1'b1, 32'h0},
			// modulus two: zero exponent, zero base, odd base
			'{1'b1, 32'h2,        32'd3,        32'h0,        1'b1, 32'h1},
			'{1'b0, 32'h0,        32'h0,        32'd5,        1'b1, 32'h0},
			'{1'b0, 32'h0,        32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 32'h1},
			'{1'b0, 32'h0,        32'h0,        32'h0,        1'b1, 32'h1},
			// small prime, base above the modulus
			'{1'b1, 32'd13,       32'd2,        32'd1,        1'b1, 32'd2},
			'{1'b0, 32'h0,        32'd15,       32'd1,        1'b1, 32'd2},
			'{1'b0, 32'h0,        32'd2,        32'd10,       1'b0, 32'h0},
			'{1'b0, 32'h0,        32'd13,       32'd5,        1'b1, 32'h0},
			// largest modulus: base equal to it, minus one squared and odd powers
			'{1'b1, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'd7,        1'b1, 32'h0},
			'{1'b0, 32'h0,        32'hFFFFFFFE, 32'd2,        1'b1, 32'h1},
			'{1'b0, 32'h0,        32'hFFFFFFFE, 32'hFFFFFFFF, 1'b1, 32'hFFFFFFFE},
			'{1'b0, 32'h0,        32'h12345678, 32'd1,        1'b1, 32'h12345678},
			'{1'b0, 32'h0,        32'h0,        32'h0,        1'b1, 32'h1},
			'{1'b0, 32'h0,        32'hDEADBEEF, 32'hFFFFFFFF, 1'b0, 32'h0},
			// largest 32-bit prime: Fermat gives one
			'{1'b1, 32'hFFFFFFFB, 32'd5,        32'hFFFFFFFA, 1'b1, 32'h1},
			'{1'b0, 32'h0,        32'hFFFFFFFF, 32'h80000000, 1'b0, 32'h0},
			// even modulus with top bit set
			'{1'b1, 32'h80000000, 32'd3,        32'hFFFFFFFF, 1'b0, 32'h0}
		};

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (int r = 0; r < DIR_N; r++) begin
			row = dir_rows[r];
			if (row.wr_mod)
				set_modulus(row.mod_val);
			send_item(row.base_val, row.exp_val, row.known, row.want, 0);
		end

		// random bursts, each under a new modulus
		rand_sent = 0;
		while (rand_sent < RANDOM_ITEMS) begin
			case ($urandom_range(9))
				0:       m = word_t'($urandom_range(1));
				1:       m = word_t'($urandom_range(255, 2));
				2:       m = 32'hFFFFFFFF;
				3:       m = 32'hFFFFFFFB;
				4:       m = 32'h80000000 | $urandom();
				default: m = $urandom();
			endcase
			set_modulus(m);
			burst = $urandom_range(26, 10);
			for (int k = 0; k < burst && rand_sent < RANDOM_ITEMS; k++) begin
				if (rand_sent < RANDOM_ITEMS / 3)
					idle_pct = IDLE_FIRST;
				else if (rand_sent < 2 * RANDOM_ITEMS / 3)
					idle_pct = IDLE_SECOND;
				else
					idle_pct = 0;
				case ($urandom_range(7))
					0:       b = '0;
					1:       b = m - word_t'(1);
					2:       b = 32'hFFFFFFFF;
					3:       b = m;
					default: b = $urandom();
				endcase
				case ($urandom_range(7))
					0:       e = word_t'($urandom_range(3));
					1:       e = 32'hFFFFFFFF;
					2:       e = word_t'(1) << $urandom_range(31);
					default: e = $urandom();
				endcase
				send_item(b, e, 1'b0, '0, idle_pct);
				rand_sent++;
			end
		end

		// drain and finish
		start <= 1'b0;
		while (power_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Ran %0d transactions (%0d directed, %0d random) under %0d modulus writes,",
			items_sent, DIR_N, rand_sent, mod_writes);
		$display("checked %0d results, %0d errors.", results_seen, errors);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

FILE: modular_exponentiation_unit.f
+incdir+rtl
rtl/mexp_pkg.sv
rtl/mexp_mulmod.sv
rtl/modular_exponentiation_unit.sv
dv/modular_exponentiation_unit_test.sv
